// ===== hdl/bcu_pkg.sv =====
package bcu_pkg;

	localparam int unsigned MAX_N      = 29;
	localparam int unsigned IDX_W      = 5;
	localparam int unsigned COEF_W     = 27;
	localparam int unsigned PROD_W     = 64;
	localparam int unsigned DEN_W      = 37;
	localparam int unsigned REM_W      = DEN_W + 1;
	localparam int unsigned CNT_W      = 5;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COEF_W - 1);

	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_load;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic inv;
		logic mul_done;
		logic div_last;
	} stat_t;

	// s! for the smaller side, s <= 14 on every valid item
	function automatic logic [DEN_W-1:0] fact(input logic [3:0] s);
		logic [DEN_W-1:0] f;
		unique case (s)
			4'd0:    f = 37'd1;
			4'd1:    f = 37'd1;
			4'd2:    f = 37'd2;
			4'd3:    f = 37'd6;
			4'd4:    f = 37'd24;
			4'd5:    f = 37'd120;
			4'd6:    f = 37'd720;
			4'd7:    f = 37'd5040;
			4'd8:    f = 37'd40320;
			4'd9:    f = 37'd362880;
			4'd10:   f = 37'd3628800;
			4'd11:   f = 37'd39916800;
			4'd12:   f = 37'd479001600;
			4'd13:   f = 37'd6227020800;
			4'd14:   f = 37'd87178291200;
			default: f = 37'd1;
		endcase
		return f;
	endfunction

endpackage

// ===== hdl/bcu_ctrl.sv =====
module bcu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bcu_pkg::stat_t stat,
	output bcu_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				priority if (stat.inv) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (stat.mul_done) begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIV;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/bcu_dp.sv =====
module bcu_dp #(
	parameter int unsigned MAX_N = bcu_pkg::MAX_N
) (
	input  logic                        clk,
	input  logic [bcu_pkg::IDX_W-1:0]   row_n,
	input  logic [bcu_pkg::IDX_W-1:0]   col_k,
	input  bcu_pkg::cmd_t               cmd,
	output bcu_pkg::stat_t              stat,
	output logic [bcu_pkg::COEF_W-1:0]  coefficient,
	output logic                        invalid
);

	logic [bcu_pkg::IDX_W-1:0]  n_q;
	logic [bcu_pkg::IDX_W-1:0]  fac_q;
	logic                       inv_q;
	logic [bcu_pkg::PROD_W-1:0] prod_q;
	logic [bcu_pkg::DEN_W-1:0]  den_q;
	logic [bcu_pkg::REM_W-1:0]  rem_q;
	logic [bcu_pkg::COEF_W-1:0] quo_q;
	logic [bcu_pkg::CNT_W-1:0]  cnt_q;
	logic [bcu_pkg::COEF_W-1:0] coef_q;
	logic                       invalid_q;

	logic [bcu_pkg::IDX_W-1:0]  rest;
	logic [bcu_pkg::IDX_W-1:0]  big;
	logic [bcu_pkg::IDX_W-1:0]  small_s;
	logic [bcu_pkg::REM_W-1:0]  trial;
	logic [bcu_pkg::REM_W-1:0]  diff;
	logic                       qbit;

	assign rest    = row_n - col_k;
	assign big     = (rest > col_k) ? rest : col_k;
	assign small_s = (rest > col_k) ? col_k : rest;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q[bcu_pkg::DEN_W-1:0], quo_q[bcu_pkg::COEF_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= row_n;
			fac_q  <= big + 5'd1;
			inv_q  <= (col_k > row_n) || (row_n > bcu_pkg::IDX_W'(MAX_N));
			prod_q <= 64'd1;
			den_q  <= bcu_pkg::fact(small_s[3:0]);
		end
		if (cmd.mul_step) begin
			prod_q <= prod_q * {{(bcu_pkg::PROD_W-bcu_pkg::IDX_W){1'b0}}, fac_q};
			fac_q  <= fac_q + 5'd1;
		end
		if (cmd.div_load) begin
			// quotient fits COEF_W bits, so the high part is already below the divisor
			rem_q <= {1'b0, prod_q[bcu_pkg::PROD_W-1:bcu_pkg::COEF_W]};
			quo_q <= prod_q[bcu_pkg::COEF_W-1:0];
			cnt_q <= bcu_pkg::DIV_LAST;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? diff : trial;
			quo_q <= {quo_q[bcu_pkg::COEF_W-2:0], qbit};
			cnt_q <= cnt_q - 5'd1;
		end
		if (cmd.finish) begin
			coef_q    <= inv_q ? '0 : quo_q;
			invalid_q <= inv_q;
		end
	end

	assign stat.inv      = inv_q;
	assign stat.mul_done = (fac_q > n_q);
	assign stat.div_last = (cnt_q == '0);

	assign coefficient = coef_q;
	assign invalid     = invalid_q;

endmodule

// ===== hdl/binomial_coefficient_unit_core.sv =====
// channel   signals                        transfer
// request   start, busy, row_n, col_k      edge with start high and busy low
// result    done, coefficient, invalid     edge ending the single cycle done is high
//
// Valid request: busy through s multiply steps, s = min(k, n-k) (at most 14 multiply
// steps on a 64x5 multiplier), then 27 restoring-division steps; done follows.
// Invalid request (k > n or n > 29): busy for one cycle, then done.
// A new request may be taken in the cycle done is shown.
// Reset clears only the controller; the receiver cannot stall a result.
module binomial_coefficient_unit_core #(
	parameter int unsigned MAX_N = bcu_pkg::MAX_N
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [bcu_pkg::IDX_W-1:0]  row_n,
	input  logic [bcu_pkg::IDX_W-1:0]  col_k,
	output logic                       done,
	output logic [bcu_pkg::COEF_W-1:0] coefficient,
	output logic                       invalid
);

	bcu_pkg::cmd_t  cmd;
	bcu_pkg::stat_t stat;

	bcu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bcu_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk         (clk),
		.row_n       (row_n),
		.col_k       (col_k),
		.cmd         (cmd),
		.stat        (stat),
		.coefficient (coefficient),
		.invalid     (invalid)
	);

endmodule

// ===== hdl/bcu_chk.sv =====
module bcu_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [bcu_pkg::COEF_W-1:0] coefficient,
	input logic                       invalid
);

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> coefficient == '0)
		else $error("invalid result with nonzero coefficient");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer taken without going busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in progress");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !invalid |-> coefficient != '0)
		else $error("valid result is zero");

endmodule

bind binomial_coefficient_unit_core bcu_chk u_bcu_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.coefficient (coefficient),
	.invalid     (invalid)
);

// ===== dv/tb_binomial_coefficient_unit_core.sv =====
`timescale 1ns / 1ps

module tb_binomial_coefficient_unit_core;

	localparam int unsigned IDX_W  = bcu_pkg::IDX_W;
	localparam int unsigned COEF_W = bcu_pkg::COEF_W;
	localparam int unsigned MAX_N  = bcu_pkg::MAX_N;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 60;

	typedef struct {
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] k;
		int unsigned      gap;
		bit               drain;
	} request_t;

	typedef struct {
		logic [COEF_W-1:0] coef;
		logic              inv;
	} coef_res_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [IDX_W-1:0]  row_n;
	logic [IDX_W-1:0]  col_k;
	logic              done;
	logic [COEF_W-1:0] coefficient;
	logic              invalid;

	request_t    request_q[$];
	coef_res_t   coef_expected_q[$];
	request_t    next_req;
	coef_res_t   got_head;
	int unsigned idle_left;
	int unsigned mismatches;
	int unsigned cycle_cnt;

	binomial_coefficient_unit_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.row_n(row_n),
		.col_k(col_k),
		.done(done),
		.coefficient(coefficient),
		.invalid(invalid)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic coef_res_t binom_predict(input logic [IDX_W-1:0] n_in,
			input logic [IDX_W-1:0] k_in);
		coef_res_t       r;
		int unsigned     n;
		int unsigned     k;
		int unsigned     big;
		int unsigned     sml;
		longint unsigned prod;
		longint unsigned fct;
		n = n_in;
		k = k_in;
		if (k > n || n > MAX_N) begin
			r.coef = '0;
			r.inv  = 1'b1;
		end else begin
			big  = (n - k > k) ? n - k : k;
			sml  = n - big;
			prod = 1;
			for (int unsigned i = big + 1; i <= n; i++)
				prod = prod * i;
			fct = 1;
			for (int unsigned i = 2; i <= sml; i++)
				fct = fct * i;
			r.coef = COEF_W'(prod / fct);
			r.inv  = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(3, 1);
		else
			return $urandom_range(60, 10);
	endfunction

	task automatic add_request(input int unsigned n, input int unsigned k,
			input int unsigned gap, input bit drain);
		request_t q;
		q.n     = IDX_W'(n);
		q.k     = IDX_W'(k);
		q.gap   = gap;
		q.drain = drain;
		request_q.push_back(q);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			row_n     <= '0;
			col_k     <= '0;
			idle_left <= 0;
		end else begin
			if (start && !busy)
				coef_expected_q.push_back(binom_predict(row_n, col_k));
			if (!(start && busy)) begin
				if (idle_left != 0) begin
					start     <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (request_q.size() != 0 &&
						!(request_q[0].drain && coef_expected_q.size() != 0)) begin
					next_req  = request_q.pop_front();
					start     <= 1'b1;
					row_n     <= next_req.n;
					col_k     <= next_req.k;
					idle_left <= next_req.gap;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (coef_expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result coefficient=%0d invalid=%0b",
					coefficient, invalid));
			end else begin
				got_head = coef_expected_q.pop_front();
				if (coefficient !== got_head.coef)
					report_mismatch($sformatf("coefficient got %0d exp %0d",
						coefficient, got_head.coef));
				if (invalid !== got_head.inv)
					report_mismatch($sformatf("invalid got %0b exp %0b",
						invalid, got_head.inv));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("binomial_coefficient_unit_core verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned k;
		int unsigned r;
		int unsigned burst;
		cycle_cnt  = 0;
		mismatches = 0;
		arst_n     = 1'b0;

		// edges, row zero, largest coefficient, column past row, row past limit
		add_request(0, 0, 0, 1'b0);
		add_request(29, 0, 0, 1'b0);
		add_request(29, 29, 1, 1'b0);
		add_request(29, 14, 0, 1'b0);
		add_request(29, 15, 2, 1'b0);
		add_request(28, 14, 0, 1'b0);
		add_request(1, 0, 0, 1'b0);
		add_request(1, 1, 0, 1'b0);
		add_request(5, 6, 0, 1'b0);
		add_request(0, 31, 0, 1'b0);
		add_request(31, 0, 3, 1'b0);
		add_request(30, 30, 0, 1'b0);
		add_request(31, 31, 0, 1'b0);
		add_request(30, 5, 0, 1'b0);
		add_request(29, 30, 0, 1'b0);
		add_request(20, 10, 0, 1'b0);
		add_request(13, 7, 0, 1'b0);
		add_request(0, 1, 0, 1'b0);
		add_request(10, 21, 0, 1'b0);
		add_request(21, 10, 0, 1'b0);

		burst = 0;
		for (int unsigned i = 0; i < 2000; i++) begin
			r = $urandom_range(99);
			if (r < 88) begin
				n = $urandom_range(MAX_N);
				k = $urandom_range(n);
			end else begin
				n = $urandom_range(31);
				k = $urandom_range(31);
			end
			if (i % 400 == 200)
				burst = 80;
			add_request(n, k, (burst != 0) ? 0 : pick_gap(), (i == 0 || i == 1000));
			if (burst != 0)
				burst--;
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_q.size() != 0 || start || coef_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("binomial_coefficient_unit_core verification clean");
		else
			$display("binomial_coefficient_unit_core verification failed");
		$finish;
	end

endmodule
